/* hdl/mpc_pkg.sv */
// Package for the MRU page cache: field widths, entry and key types,
// status codes and the table update command. No dependencies.
`default_nettype none
package mpc_pkg;

  localparam int DEF_ENTRIES = 5;
  localparam int DOC_W       = 8;
  localparam int PAGE_W      = 16;
  localparam int ANGLE_W     = 2;
  localparam int COUNT_W     = 15;
  localparam int BUF_W       = 3;
  localparam int MODE_W      = 2;
  localparam int PREV_W      = PAGE_W + 1;
  localparam int RA_W        = PAGE_W + 2;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam int MODE_FLUSH_BIT = 1;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FILLED  = 3'd1,
    ST_FAILED  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_FLUSHED = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [DOC_W-1:0]   doc;
    logic [PAGE_W-1:0]  page;
    logic [ANGLE_W-1:0] angle;
  } key_t;

  typedef struct packed {
    logic             valid;
    key_t             key;
    logic [BUF_W-1:0] buf_num;
  } entry_t;

  // fill: write key at pos as valid and rotate it to the front (hit or load)
  // inval: clear valid of the entry at pos (load failed)
  typedef struct packed {
    logic             flush;
    logic             fill;
    logic             inval;
    logic [BUF_W-1:0] pos;
    key_t             key;
  } tbl_op_t;

endpackage
`default_nettype wire

/* hdl/mpc_tag_cmp.sv */
// Tag compare unit: checks one cache entry against the lookup key.
// Depends on mpc_pkg.
`default_nettype none
module mpc_tag_cmp
  import mpc_pkg::*;
(
  input  key_t   key,
  input  entry_t entry,
  output logic   hit
);

  assign hit = entry.valid && (entry.key.doc == key.doc) &&
               (entry.key.page == key.page) && (entry.key.angle == key.angle);

endmodule
`default_nettype wire

/* hdl/mpc_entries.sv */
// Entry table in MRU order with one scan read port and move-to-front update.
// Depends on mpc_pkg.
`default_nettype none
module mpc_entries
  import mpc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  tbl_op_t          op,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_entry
);

  entry_t ent [ENTRIES];
  logic [IDX_W-1:0] pos;

  assign pos      = op.pos[IDX_W-1:0];
  assign rd_entry = ent[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) begin
        ent[k].valid   <= 1'b0;
        ent[k].buf_num <= BUF_W'(k);
      end
    end else if (op.flush) begin
      for (int k = 0; k < ENTRIES; k++) begin
        ent[k].valid <= 1'b0;
      end
    end else if (op.fill) begin
      ent[0].valid   <= 1'b1;
      ent[0].key     <= op.key;
      ent[0].buf_num <= ent[pos].buf_num;
      for (int k = 1; k < ENTRIES; k++) begin
        if (IDX_W'(k) <= pos) begin
          ent[k] <= ent[k-1];
        end
      end
    end else if (op.inval) begin
      ent[pos].valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hdl/mpc_ctrl.sv */
// Request sequencer: front checks, readahead detection, entry scan and
// result registers. Depends on mpc_pkg.
`default_nettype none
module mpc_ctrl
  import mpc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MODE_W-1:0]  mode,
  input  logic [DOC_W-1:0]   doc_id,
  input  logic [PAGE_W-1:0]  page_num,
  input  logic [ANGLE_W-1:0] angle_code,
  input  logic [COUNT_W-1:0] page_count,
  input  logic               forward_only,
  input  logic               load_ok,
  input  logic               readahead_busy,
  input  entry_t             rd_entry,
  input  logic               hit,
  output logic [IDX_W-1:0]   rd_idx,
  output key_t               key,
  output tbl_op_t            op,
  output logic               busy,
  output logic               done,
  output logic [2:0]         status,
  output logic [BUF_W-1:0]   buffer_index,
  output logic               readahead_valid,
  output logic [COUNT_W-1:0] readahead_page
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  state_t             state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  key_t               key_next;
  logic               ok, ok_next;
  logic [PREV_W-1:0]  prev, prev_next;
  logic               ra_v, ra_v_next;
  logic [COUNT_W-1:0] ra_p, ra_p_next;
  logic               done_next;
  status_t            stat, stat_next;
  logic [BUF_W-1:0]   bufi, bufi_next;
  logic               rav_out, rav_out_next;
  logic [COUNT_W-1:0] rap_out, rap_out_next;

  logic signed [RA_W-1:0] page_x, prev_x, ra_up, ra_dn;
  logic                   range_bad, up_ok, dn_ok;

  always_comb begin
    page_x    = RA_W'($signed(page_num));
    prev_x    = RA_W'($signed(prev));
    ra_up     = page_x + RA_W'(1);
    ra_dn     = page_x - RA_W'(1);
    up_ok     = (page_x == prev_x + RA_W'(1)) && (ra_up[RA_W-1:COUNT_W] == '0);
    dn_ok     = (page_x == prev_x - RA_W'(1)) && (ra_dn[RA_W-1:COUNT_W] == '0);
    range_bad = !forward_only &&
                (page_num[PAGE_W-1] || (page_num[COUNT_W-1:0] >= page_count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      prev    <= '1;
      idx     <= '0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      prev    <= prev_next;
      idx     <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    ok      <= ok_next;
    ra_v    <= ra_v_next;
    ra_p    <= ra_p_next;
    stat    <= stat_next;
    bufi    <= bufi_next;
    rav_out <= rav_out_next;
    rap_out <= rap_out_next;
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    key_next     = key;
    ok_next      = ok;
    prev_next    = prev;
    ra_v_next    = ra_v;
    ra_p_next    = ra_p;
    done_next    = 1'b0;
    stat_next    = stat;
    bufi_next    = bufi;
    rav_out_next = rav_out;
    rap_out_next = rap_out;
    op           = '0;
    op.pos       = BUF_W'(idx);
    op.key       = key;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          bufi_next    = '0;
          rav_out_next = 1'b0;
          rap_out_next = '0;
          if (mode[MODE_FLUSH_BIT]) begin
            op.flush  = 1'b1;
            stat_next = ST_FLUSHED;
            done_next = 1'b1;
          end else if (mode == MODE_NORMAL && page_count == '0) begin
            stat_next = ST_EMPTY;
            done_next = 1'b1;
          end else if (range_bad) begin
            stat_next = ST_RANGE;
            done_next = 1'b1;
          end else begin
            key_next   = '{doc: doc_id, page: page_num, angle: angle_code};
            ok_next    = load_ok;
            idx_next   = '0;
            ra_v_next  = 1'b0;
            ra_p_next  = '0;
            state_next = S_SCAN;
            if (mode == MODE_NORMAL) begin
              prev_next = PREV_W'($signed(page_num));
              if (!readahead_busy) begin
                if (up_ok) begin
                  ra_v_next = 1'b1;
                  ra_p_next = ra_up[COUNT_W-1:0];
                end else if (dn_ok) begin
                  ra_v_next = 1'b1;
                  ra_p_next = ra_dn[COUNT_W-1:0];
                end
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (hit || !rd_entry.valid || idx == LAST) begin
          bufi_next    = rd_entry.buf_num;
          rav_out_next = ra_v;
          rap_out_next = ra_p;
          done_next    = 1'b1;
          state_next   = S_IDLE;
          if (hit) begin
            op.fill   = 1'b1;
            stat_next = ST_HIT;
          end else if (ok) begin
            op.fill   = 1'b1;
            stat_next = ST_FILLED;
          end else begin
            op.inval  = 1'b1;
            stat_next = ST_FAILED;
          end
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rd_idx          = idx;
  assign busy            = (state == S_SCAN);
  assign status          = stat;
  assign buffer_index    = bufi;
  assign readahead_valid = rav_out;
  assign readahead_page  = rap_out;

endmodule
`default_nettype wire

/* hdl/mru_page_cache_with_readahead_unit.sv */
// Top level of the MRU page cache with readahead detection.
// Depends on mpc_pkg, mpc_ctrl, mpc_entries and mpc_tag_cmp.
//
// A transaction is taken when start is high and busy is low. Flush, empty
// document and out-of-range requests finish at once: the result shows with
// done in the next cycle. A lookup scans the entries one per cycle
// through a single tag comparator, from the front to the first hit, the
// first empty entry or the last entry, and updates the table in the cycle
// that ends the scan. It keeps busy high while it scans, and done rises as
// busy falls. Done is high for exactly one cycle per result; there is no
// back-pressure, and the result registers keep the result on the ports until
// the next transaction is accepted. No clearing pass after reset.
`default_nettype none
module mru_page_cache_with_readahead_unit
  import mpc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [DOC_W-1:0]   doc_id,
  input  logic [PAGE_W-1:0]  page_num,
  input  logic [ANGLE_W-1:0] angle_code,
  input  logic [COUNT_W-1:0] page_count,
  input  logic               forward_only,
  input  logic               load_ok,
  input  logic               readahead_busy,
  output logic               done,
  output logic [2:0]         status,
  output logic [BUF_W-1:0]   buffer_index,
  output logic               readahead_valid,
  output logic [COUNT_W-1:0] readahead_page
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_entry;
  key_t             key;
  tbl_op_t          op;
  logic             hit;

  mpc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk, .rst, .start, .mode, .doc_id, .page_num, .angle_code, .page_count,
    .forward_only, .load_ok, .readahead_busy, .rd_entry, .hit, .rd_idx, .key,
    .op, .busy, .done, .status, .buffer_index, .readahead_valid,
    .readahead_page
  );

  mpc_entries #(.ENTRIES(ENTRIES)) u_entries (
    .clk, .rst, .op, .rd_idx, .rd_entry
  );

  mpc_tag_cmp u_cmp (
    .key, .entry(rd_entry), .hit
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while scan still running");

  a_ra_lookup: assert property (@(posedge clk) disable iff (rst)
    (done && readahead_valid) |->
      (status == ST_HIT || status == ST_FILLED || status == ST_FAILED))
    else $error("readahead proposed outside a lookup");

  a_buf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_RANGE || status == ST_EMPTY || status == ST_FLUSHED))
      |-> (buffer_index == '0 && !readahead_valid))
    else $error("payload set on a short result");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $countones({op.flush, op.fill, op.inval}) <= 1)
    else $error("conflicting table updates");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("scan ended without a result");

endmodule
`default_nettype wire
